// ===== rtl/core/spn_pkg.sv =====
`timescale 1ns / 1ps

package spn_pkg;

  // schedule address and round number fields are sized for the largest configuration
  localparam int ADDR_W  = 8;
  localparam int ROUND_W = 6;

  localparam int KEY_BYTES_DEF  = 64;
  localparam int ROUNDS_DEF     = 10;
  localparam int MIX_PASSES_DEF = 32;

  localparam logic [7:0] SCHED_FILL = 8'h5A;

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_NONE = 2'd3
  } spn_op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  pass_byte;
    logic        pass_last;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } spn_in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } spn_out_t;

  // datapath commands
  typedef enum logic [3:0] {
    DP_NOP     = 4'd0,
    DP_LOAD    = 4'd1,
    DP_CLR     = 4'd2,
    DP_PB      = 4'd3,
    DP_MIX_CUR = 4'd4,
    DP_MIX_WR  = 4'd5,
    DP_RK      = 4'd6,
    DP_APPLY   = 4'd7,
    DP_OUT     = 4'd8
  } spn_dp_op_t;

  typedef struct packed {
    spn_dp_op_t          op;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                use_first;
    logic                set_first;
    logic                decrypt;
    logic [ROUND_W-1:0]  round;
  } spn_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_REV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [3:0] FWD_ORDER  [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };

  localparam logic [3:0] BACK_ORDER [16] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
    blk_byte = b[127-8*i -: 8];
  endfunction

endpackage

// ===== rtl/core/spn_ram.sv =====
`timescale 1ns / 1ps

module spn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/spn_ctrl.sv =====
`timescale 1ns / 1ps

module spn_ctrl
  import spn_pkg::*;
#(
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int ROUNDS     = ROUNDS_DEF,
  parameter int MIX_PASSES = MIX_PASSES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  spn_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output spn_cmd_t cmd
);

  localparam int AW = $clog2(KEY_BYTES);
  localparam int RW = $clog2(ROUNDS + 1);
  localparam int PW = $clog2(MIX_PASSES + 1);
  localparam int D32 = 32 % KEY_BYTES;
  localparam logic [AW-1:0] LAST_IDX  = AW'(KEY_BYTES - 1);
  localparam logic [AW-1:0] DEC_START = AW'((16 * ROUNDS) % KEY_BYTES);
  localparam logic [AW-1:0] STEP_BACK = AW'(D32);
  localparam logic [AW-1:0] WRAP_BACK = AW'(KEY_BYTES - D32);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_PB_RD  = 10'b0000000100,
    S_PB_WR  = 10'b0000001000,
    S_MX_RD0 = 10'b0000010000,
    S_MX_RD  = 10'b0000100000,
    S_MX_WR  = 10'b0001000000,
    S_RK     = 10'b0010000000,
    S_APPLY  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] ka_r, ka_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic [4:0]    k_r, k_nxt;
  logic          restart_r, restart_nxt;
  logic          pend_r, pend_nxt;
  logic          last_r, last_nxt;
  logic          dec_r, dec_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] j_inc, ka_inc, fill_inc;

  assign j_inc    = (j_r == LAST_IDX) ? '0 : j_r + 1'b1;
  assign ka_inc   = (ka_r == LAST_IDX) ? '0 : ka_r + 1'b1;
  assign fill_inc = (fill_r == LAST_IDX) ? '0 : fill_r + 1'b1;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    ka_nxt        = ka_r;
    fill_nxt      = fill_r;
    pass_nxt      = pass_r;
    round_nxt     = round_r;
    k_nxt         = k_r;
    restart_nxt   = restart_r;
    pend_nxt      = pend_r;
    last_nxt      = last_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.op        = DP_NOP;
    cmd.decrypt   = dec_r;
    cmd.round     = ROUND_W'(round_r);

    unique case (state_r)
      S_CLEAR: begin
        cmd.op      = DP_CLR;
        cmd.wr_addr = ADDR_W'(j_r);
        j_nxt       = j_inc;
        if (j_r == LAST_IDX) begin
          if (pend_r) begin
            pend_nxt  = 1'b0;
            state_nxt = S_PB_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          unique case (spn_op_t'(in_data.operation))
            OP_PASS: begin
              last_nxt = in_data.pass_last;
              if (restart_r) begin
                restart_nxt = 1'b0;
                fill_nxt    = '0;
                pend_nxt    = 1'b1;
                j_nxt       = '0;
                state_nxt   = S_CLEAR;
              end else begin
                state_nxt = S_PB_RD;
              end
            end
            OP_ENC: begin
              dec_nxt   = 1'b0;
              round_nxt = '0;
              ka_nxt    = '0;
              k_nxt     = '0;
              state_nxt = S_RK;
            end
            OP_DEC: begin
              dec_nxt   = 1'b1;
              round_nxt = RW'(ROUNDS);
              ka_nxt    = DEC_START;
              k_nxt     = '0;
              state_nxt = S_RK;
            end
            OP_NONE: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PB_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = ADDR_W'(fill_r);
        state_nxt   = S_PB_WR;
      end
      S_PB_WR: begin
        cmd.op      = DP_PB;
        cmd.wr_addr = ADDR_W'(fill_r);
        fill_nxt    = fill_inc;
        if (last_r) begin
          pass_nxt  = '0;
          j_nxt     = '0;
          state_nxt = S_MX_RD0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // mixing: read byte 0 at the start of each pass
      S_MX_RD0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
        state_nxt   = S_MX_RD;
      end
      S_MX_RD: begin
        if (j_r == '0) begin
          cmd.op = DP_MIX_CUR;
        end
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = ADDR_W'(j_inc);
        state_nxt   = S_MX_WR;
      end
      S_MX_WR: begin
        cmd.op        = DP_MIX_WR;
        cmd.wr_addr   = ADDR_W'(j_r);
        cmd.use_first = (j_r == LAST_IDX);
        cmd.set_first = (j_r == '0);
        j_nxt         = j_inc;
        if (j_r == LAST_IDX) begin
          if (pass_r == PW'(MIX_PASSES - 1)) begin
            restart_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            pass_nxt  = pass_r + 1'b1;
            state_nxt = S_MX_RD0;
          end
        end else begin
          state_nxt = S_MX_RD;
        end
      end
      // fetch 16 round key bytes, one per cycle
      S_RK: begin
        if (k_r < 5'd16) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = ADDR_W'(ka_r);
          ka_nxt      = ka_inc;
        end
        if (k_r != 5'd0) begin
          cmd.op = DP_RK;
        end
        if (k_r == 5'd16) begin
          k_nxt     = '0;
          state_nxt = S_APPLY;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_APPLY: begin
        cmd.op = DP_APPLY;
        if (dec_r) begin
          if (round_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            round_nxt = round_r - 1'b1;
            ka_nxt    = (ka_r >= STEP_BACK) ? ka_r - STEP_BACK : ka_r + WRAP_BACK;
            state_nxt = S_RK;
          end
        end else begin
          if (round_r == RW'(ROUNDS)) begin
            state_nxt = S_DONE;
          end else begin
            round_nxt = round_r + 1'b1;
            state_nxt = S_RK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      j_r         <= '0;
      ka_r        <= '0;
      fill_r      <= '0;
      pass_r      <= '0;
      round_r     <= '0;
      k_r         <= '0;
      restart_r   <= 1'b0;
      pend_r      <= 1'b0;
      last_r      <= 1'b0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      ka_r        <= ka_nxt;
      fill_r      <= fill_nxt;
      pass_r      <= pass_nxt;
      round_r     <= round_nxt;
      k_r         <= k_nxt;
      restart_r   <= restart_nxt;
      pend_r      <= pend_nxt;
      last_r      <= last_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/spn_dp.sv =====
`timescale 1ns / 1ps

module spn_dp
  import spn_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic     clk,
  input  spn_in_t  in_data,
  input  spn_cmd_t cmd,
  output spn_out_t out_data
);

  localparam int AW = $clog2(KEY_BYTES);

  logic [127:0] blk_r;
  logic [127:0] rk_r;
  logic [7:0]   pb_r;
  logic [7:0]   cur_r;
  logic [7:0]   first_r;
  spn_out_t     out_r;

  logic         wr_en;
  logic [7:0]   wr_data;
  logic [7:0]   rd_data;
  logic [7:0]   mix_next;
  logic [7:0]   mix_val;
  logic [127:0] rk_x;
  logic [127:0] enc_blk;
  logic [127:0] dec_blk;
  logic [127:0] dec_in;

  // key schedule store
  spn_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_sched (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd.wr_addr[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // schedule byte update
  assign mix_next = cmd.use_first ? first_r : rd_data;
  assign mix_val  = SBOX[cur_r ^ mix_next];
  assign wr_en    = (cmd.op == DP_CLR) || (cmd.op == DP_PB) || (cmd.op == DP_MIX_WR);

  always_comb begin
    unique case (cmd.op)
      DP_CLR:  wr_data = SCHED_FILL;
      DP_PB:   wr_data = rd_data ^ pb_r;
      default: wr_data = mix_val;
    endcase
  end

  // round key with the round number folded in, and both round functions
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rk_x[127-8*i -: 8] = blk_byte(rk_r, i) ^ {2'b00, cmd.round};
    end
    dec_in = blk_r ^ rk_x;
    for (int i = 0; i < 16; i++) begin
      enc_blk[127-8*i -: 8] = SBOX[blk_byte(blk_r, int'(FWD_ORDER[i]))] ^ rk_x[127-8*i -: 8];
      dec_blk[127-8*i -: 8] = SBOX_REV[blk_byte(dec_in, int'(BACK_ORDER[i]))];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        blk_r <= {in_data.block_high, in_data.block_low};
        pb_r  <= in_data.pass_byte;
      end
      DP_MIX_CUR: begin
        cur_r <= rd_data;
      end
      DP_MIX_WR: begin
        cur_r <= mix_next;
        if (cmd.set_first) begin
          first_r <= mix_val;
        end
      end
      DP_RK: begin
        rk_r <= {rk_r[119:0], rd_data};
      end
      DP_APPLY: begin
        if (cmd.round == '0) begin
          blk_r <= dec_in;
        end else if (cmd.decrypt) begin
          blk_r <= dec_blk;
        end else begin
          blk_r <= enc_blk;
        end
      end
      DP_OUT: begin
        out_r <= {blk_r[127:64], blk_r[63:0]};
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/spn_block_cipher_with_key_mix.sv =====
`timescale 1ns / 1ps

// 128-bit substitution-permutation block cipher with a passphrase-mixed key
// schedule held in a byte RAM with one write port and one registered read
// port. Each passphrase byte is read from the store and written back XORed
// in; the last one adds MIX_PASSES passes of in-place schedule mixing, and the
// first byte of a new passphrase first refills the store. After reset the
// block stalls its input while the store is filled with 0x5A. A block's
// result is presented in the same cycle that the input is free again: each
// round reads its 16 key bytes one per cycle through the schedule RAM's read
// port, then applies the round. Results sit in an output register, so the
// next transaction is accepted while a result is still stalled.
module spn_block_cipher_with_key_mix
  import spn_pkg::*;
#(
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int ROUNDS     = ROUNDS_DEF,
  parameter int MIX_PASSES = MIX_PASSES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spn_out_t out_data
);

  spn_cmd_t cmd;

  spn_ctrl #(
    .KEY_BYTES  (KEY_BYTES),
    .ROUNDS     (ROUNDS),
    .MIX_PASSES (MIX_PASSES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spn_dp #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // store is swept after reset before any transaction
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during schedule fill");

  // a block keeps the block busy on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_data.operation == OP_ENC || in_data.operation == OP_DEC)) |=> in_stall)
    else $error("block accepted without going busy");

  // a result only appears out of a busy phase
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");
`endif

endmodule
